// File: design/ipsc_pkg.sv
`default_nettype none

package ipsc_pkg;

  localparam int CENTRE_W   = 8;
  localparam int CENTRE_NUM = 9;
  localparam int ENC_W      = 12;
  localparam int MODE_W     = 2;
  localparam int DUTY_W     = 13;
  localparam int SPEED_W    = 8;
  localparam int DIST_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic signed [13:0] DRIVE_LIMIT     = 14'sd5000;
  localparam logic signed [12:0] BANG_THRESHOLD  = 13'sd20;
  localparam logic signed [12:0] TRAVEL_STEP     = 13'sd350;
  localparam logic signed [12:0] REMAINDER_FLOOR = 13'sh1000;

  // floor(n / 10) == (n * RECIP10) >> RECIP_SHIFT for every n below 2^26
  localparam logic [23:0] RECIP10     = 24'd13421773;
  localparam int          RECIP_SHIFT = 27;

  localparam logic [1:0] MODE_CROSSING = 2'd1;
  localparam logic [1:0] MODE_SLOW     = 2'd2;

  localparam logic [7:0] STRAIGHT_RESET  = 8'd70;
  localparam logic [7:0] CURVE_RESET     = 8'd55;
  localparam logic [7:0] SLOW_RESET      = 8'd40;
  localparam logic [7:0] BAND_HIGH_RESET = 8'd52;
  localparam logic [7:0] BAND_LOW_RESET  = 8'd28;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN,
    CFG_INTEG_GAIN,
    CFG_DERIV_GAIN,
    CFG_STRAIGHT_SPEED,
    CFG_CURVE_SPEED,
    CFG_SLOW_SPEED,
    CFG_BAND_HIGH,
    CFG_BAND_LOW
  } cfg_idx_t;

endpackage

`default_nettype wire

// File: design/ipsc_channels.sv
`default_nettype none

interface ipsc_in_if import ipsc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CENTRE_W-1:0]        centre_row_a;
  logic [CENTRE_W-1:0]        centre_row_b;
  logic [CENTRE_W-1:0]        centre_row_c;
  logic [CENTRE_W-1:0]        centre_row_d;
  logic [CENTRE_W-1:0]        centre_row_e;
  logic [CENTRE_W-1:0]        centre_row_f;
  logic [CENTRE_W-1:0]        centre_row_g;
  logic [CENTRE_W-1:0]        centre_row_h;
  logic [CENTRE_W-1:0]        centre_row_i;
  logic signed [ENC_W-1:0]    encoder_count;
  logic [MODE_W-1:0]          road_mode;
  logic                       halt;

  modport source (
    output valid, centre_row_a, centre_row_b, centre_row_c, centre_row_d,
           centre_row_e, centre_row_f, centre_row_g, centre_row_h, centre_row_i,
           encoder_count, road_mode, halt,
    input  ready
  );
  modport sink (
    input  valid, centre_row_a, centre_row_b, centre_row_c, centre_row_d,
           centre_row_e, centre_row_f, centre_row_g, centre_row_h, centre_row_i,
           encoder_count, road_mode, halt,
    output ready
  );
endinterface

interface ipsc_out_if import ipsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  forward_duty;
  logic [DUTY_W-1:0]  reverse_duty;
  logic [SPEED_W-1:0] target_speed;
  logic [DIST_W-1:0]  distance_units;

  modport source (
    output valid, forward_duty, reverse_duty, target_speed, distance_units,
    input  ready
  );
  modport sink (
    input  valid, forward_duty, reverse_duty, target_speed, distance_units,
    output ready
  );
endinterface

interface ipsc_cfg_if import ipsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/incremental_pid_speed_controller_top.sv
`default_nettype none

// Incremental PID speed controller, one request per control tick. The block is
// a five-register pipeline (input, target/error, gain products, divide by ten,
// result) and takes a new request every cycle while the result side keeps up.
// The error history and travel counter advance in the second stage and the
// drive level in the last, so each feedback path closes within its own stage.
// The configuration port is always ready; write it only while the pipeline is
// empty.
module incremental_pid_speed_controller_top import ipsc_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  ipsc_in_if.sink   in_ch,
  ipsc_out_if.source out_ch,
  ipsc_cfg_if.sink  cfg_ch
);

  // Configuration registers
  logic [9:0] prop_gain_r;
  logic [7:0] integ_gain_r;
  logic [9:0] deriv_gain_r;
  logic [7:0] straight_speed_r;
  logic [7:0] curve_speed_r;
  logic [7:0] slow_speed_r;
  logic [7:0] band_high_r;
  logic [7:0] band_low_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r      <= '0;
      integ_gain_r     <= '0;
      deriv_gain_r     <= '0;
      straight_speed_r <= STRAIGHT_RESET;
      curve_speed_r    <= CURVE_RESET;
      slow_speed_r     <= SLOW_RESET;
      band_high_r      <= BAND_HIGH_RESET;
      band_low_r       <= BAND_LOW_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_PROP_GAIN:      prop_gain_r      <= cfg_ch.data;
        CFG_INTEG_GAIN:     integ_gain_r     <= cfg_ch.data[7:0];
        CFG_DERIV_GAIN:     deriv_gain_r     <= cfg_ch.data;
        CFG_STRAIGHT_SPEED: straight_speed_r <= cfg_ch.data[7:0];
        CFG_CURVE_SPEED:    curve_speed_r    <= cfg_ch.data[7:0];
        CFG_SLOW_SPEED:     slow_speed_r     <= cfg_ch.data[7:0];
        CFG_BAND_HIGH:      band_high_r      <= cfg_ch.data[7:0];
        CFG_BAND_LOW:       band_low_r       <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic v0_r, v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic load1, load2, load3, load4;

  assign rdy4 = !out_valid_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = !v0_r || rdy1;

  assign load1 = v0_r && rdy1;
  assign load2 = v1_r && rdy2;
  assign load3 = v2_r && rdy3;
  assign load4 = v3_r && rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) v0_r        <= in_ch.valid;
      if (rdy1)        v1_r        <= v0_r;
      if (rdy2)        v2_r        <= v1_r;
      if (rdy3)        v3_r        <= v2_r;
      if (rdy4)        out_valid_r <= v3_r;
    end
  end

  // Stage 0: input register
  logic [CENTRE_W-1:0]     centre_r [CENTRE_NUM];
  logic signed [ENC_W-1:0] enc0_r;
  logic [MODE_W-1:0]       mode0_r;
  logic                    halt0_r;

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      centre_r[0] <= in_ch.centre_row_a;
      centre_r[1] <= in_ch.centre_row_b;
      centre_r[2] <= in_ch.centre_row_c;
      centre_r[3] <= in_ch.centre_row_d;
      centre_r[4] <= in_ch.centre_row_e;
      centre_r[5] <= in_ch.centre_row_f;
      centre_r[6] <= in_ch.centre_row_g;
      centre_r[7] <= in_ch.centre_row_h;
      centre_r[8] <= in_ch.centre_row_i;
      enc0_r      <= in_ch.encoder_count;
      mode0_r     <= in_ch.road_mode;
      halt0_r     <= in_ch.halt;
    end
  end

  // Stage 1: target choice, error history, travel
  logic [11:0]        centre_sum;
  logic [12:0]        high_edge;
  logic [11:0]        low_edge;
  logic               off_band;
  logic [7:0]         target_nxt;
  logic               straight_nxt;
  logic signed [12:0] e0_nxt;
  logic signed [13:0] speed;
  logic signed [13:0] rem_sum;
  logic signed [12:0] rem_nxt;
  logic               step_hit;

  logic signed [12:0] hist_r [3];
  logic signed [12:0] rem_r;
  logic [DIST_W-1:0]  travel_count_r;
  logic [7:0]         target1_r;
  logic               straight1_r;
  logic               halt1_r;

  always_comb begin
    centre_sum = '0;
    for (int k = 0; k < CENTRE_NUM; k++) begin
      centre_sum = centre_sum + 12'(centre_r[k]);
    end
    // compare the sum against nine times each band edge instead of dividing
    high_edge = ({4'b0, band_high_r} + 13'd1) * 13'd9;
    low_edge  = {4'b0, band_low_r} * 12'd9;
    off_band  = ({1'b0, centre_sum} >= high_edge) || (centre_sum < low_edge);

    straight_nxt = 1'b0;
    if (mode0_r == MODE_SLOW) begin
      target_nxt = slow_speed_r;
    end else if (mode0_r != MODE_CROSSING && off_band) begin
      target_nxt = curve_speed_r;
    end else begin
      target_nxt   = straight_speed_r;
      straight_nxt = 1'b1;
    end

    e0_nxt = $signed({5'b0, target_nxt}) + 13'(enc0_r);
    speed  = -14'(enc0_r);

    rem_sum  = 14'(rem_r) + speed;
    step_hit = rem_sum > 14'(TRAVEL_STEP);
    if (step_hit) begin
      rem_nxt = '0;
    end else if (rem_sum < 14'(REMAINDER_FLOOR)) begin
      rem_nxt = REMAINDER_FLOOR;
    end else begin
      rem_nxt = 13'(rem_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r[0]      <= '0;
      hist_r[1]      <= '0;
      hist_r[2]      <= '0;
      rem_r          <= '0;
      travel_count_r <= '0;
    end else if (load1) begin
      hist_r[2] <= hist_r[1];
      hist_r[1] <= hist_r[0];
      hist_r[0] <= e0_nxt;
      rem_r     <= rem_nxt;
      if (step_hit) travel_count_r <= travel_count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      target1_r   <= target_nxt;
      straight1_r <= straight_nxt;
      halt1_r     <= halt0_r;
    end
  end

  // Stage 2: gain products
  logic signed [13:0] diff1;
  logic signed [14:0] diff2;
  logic signed [21:0] iprod;
  logic signed [24:0] pprod;
  logic signed [25:0] dprod;

  logic signed [21:0] iprod2_r;
  logic signed [24:0] pprod2_r;
  logic signed [25:0] dprod2_r;
  logic signed [12:0] e0_2_r;
  logic [7:0]         target2_r;
  logic               straight2_r;
  logic               halt2_r;
  logic [DIST_W-1:0]  dist2_r;

  always_comb begin
    diff1 = 14'(hist_r[0]) - 14'(hist_r[1]);
    diff2 = 15'(hist_r[0]) - (15'(hist_r[1]) <<< 1) + 15'(hist_r[2]);
    iprod = 22'(hist_r[0]) * $signed({14'b0, integ_gain_r});
    pprod = 25'(diff1) * $signed({15'b0, prop_gain_r});
    dprod = 26'(diff2) * $signed({16'b0, deriv_gain_r});
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      iprod2_r    <= iprod;
      pprod2_r    <= pprod;
      dprod2_r    <= dprod;
      e0_2_r      <= hist_r[0];
      target2_r   <= target1_r;
      straight2_r <= straight1_r;
      halt2_r     <= halt1_r;
      dist2_r     <= travel_count_r;
    end
  end

  // Stage 3: divide P and D by ten, truncating toward zero
  function automatic logic signed [21:0] div10(input logic signed [25:0] n);
    logic [25:0] mag;
    logic [47:0] prod;
    logic [20:0] quo;
    mag  = n[25] ? 26'(-n) : 26'(n);
    prod = mag[23:0] * RECIP10;
    quo  = prod[RECIP_SHIFT+20:RECIP_SHIFT];
    return n[25] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  endfunction

  logic signed [21:0] i3_r;
  logic signed [21:0] p3_r;
  logic signed [21:0] d3_r;
  logic signed [12:0] e0_3_r;
  logic [7:0]         target3_r;
  logic               straight3_r;
  logic               halt3_r;
  logic [DIST_W-1:0]  dist3_r;

  always_ff @(posedge clk) begin
    if (load3) begin
      i3_r        <= iprod2_r;
      p3_r        <= div10(26'(pprod2_r));
      d3_r        <= div10(dprod2_r);
      e0_3_r      <= e0_2_r;
      target3_r   <= target2_r;
      straight3_r <= straight2_r;
      halt3_r     <= halt2_r;
      dist3_r     <= dist2_r;
    end
  end

  // Stage 4: accumulate drive, override, clamp, split into duties
  logic signed [24:0] drive_sum;
  logic signed [24:0] drive_sel;
  logic signed [13:0] drive_nxt;
  logic [DUTY_W-1:0]  fwd_nxt;
  logic [DUTY_W-1:0]  rev_nxt;

  logic signed [13:0] drive_r;
  logic [DUTY_W-1:0]  fwd_r;
  logic [DUTY_W-1:0]  rev_r;
  logic [SPEED_W-1:0] target_out_r;
  logic [DIST_W-1:0]  dist_out_r;

  always_comb begin
    drive_sum = 25'(drive_r) + 25'(i3_r) + 25'(p3_r) + 25'(d3_r);
    drive_sel = drive_sum;
    if (e0_3_r >= BANG_THRESHOLD && straight3_r) drive_sel = 25'(DRIVE_LIMIT);
    if (e0_3_r <= -BANG_THRESHOLD) drive_sel = -25'(DRIVE_LIMIT);

    if (drive_sel > 25'(DRIVE_LIMIT)) begin
      drive_nxt = DRIVE_LIMIT;
    end else if (drive_sel < -25'(DRIVE_LIMIT)) begin
      drive_nxt = -DRIVE_LIMIT;
    end else begin
      drive_nxt = 14'(drive_sel);
    end

    fwd_nxt = '0;
    rev_nxt = '0;
    if (!halt3_r) begin
      if (drive_nxt > 14'sd0) begin
        fwd_nxt = 13'(drive_nxt);
      end else begin
        rev_nxt = 13'(-drive_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= '0;
    end else if (load4) begin
      drive_r <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load4) begin
      fwd_r        <= fwd_nxt;
      rev_r        <= rev_nxt;
      target_out_r <= target3_r;
      dist_out_r   <= dist3_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.forward_duty   = fwd_r;
  assign out_ch.reverse_duty   = rev_r;
  assign out_ch.target_speed   = target_out_r;
  assign out_ch.distance_units = dist_out_r;

  // Checks
  a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (drive_r <= DRIVE_LIMIT) && (drive_r >= -DRIVE_LIMIT))
    else $error("drive level outside limit");

  a_remainder_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r <= TRAVEL_STEP) && (rem_r >= REMAINDER_FLOOR))
    else $error("travel remainder outside range");

  a_state_holds_without_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !load1 |=> $stable(travel_count_r) && $stable(rem_r) && $stable(hist_r[0]))
    else $error("error history or travel changed without a request advancing");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
module tb_top;
  import ipsc_pkg::*;

  localparam logic [MODE_W-1:0] ROAD_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] ROAD_SPARE  = 2'd3;
  localparam logic [DUTY_W-1:0] DUTY_FULL   = 13'd5000;

  localparam int PIPE_SETTLE     = 8;
  localparam int HOLD_CYCLES     = 60;
  localparam int STALL_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int PHASES          = 6;
  localparam int PLAN_ROWS       = 19;

  typedef struct packed {
    logic [CENTRE_NUM-1:0][CENTRE_W-1:0] centre;
    logic signed [ENC_W-1:0]             enc;
    logic [MODE_W-1:0]                   mode;
    logic                                halt;
  } tick_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  fwd;
    logic [DUTY_W-1:0]  rev;
    logic [SPEED_W-1:0] tgt;
    logic [DIST_W-1:0]  distance;
  } duty_result_t;

  typedef struct packed {
    logic [CENTRE_W-1:0]     first;
    logic [CENTRE_W-1:0]     rest;
    logic signed [ENC_W-1:0] enc;
    logic [MODE_W-1:0]       mode;
    logic                    halt;
    duty_result_t            want;
  } plan_row_t;

  typedef struct packed {
    logic [9:0] prop_gain;
    logic [7:0] integ_gain;
    logic [9:0] deriv_gain;
    logic [7:0] straight_speed;
    logic [7:0] curve_speed;
    logic [7:0] slow_speed;
    logic [7:0] band_high;
    logic [7:0] band_low;
  } ctrl_cfg_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ipsc_in_if  in_ch();
  ipsc_out_if out_ch();
  ipsc_cfg_if cfg_ch();

  incremental_pid_speed_controller_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Mirror of the controller: settings, error history, drive and odometer.
  ctrl_cfg_t gains = '{10'd0, 8'd0, 10'd0, STRAIGHT_RESET, CURVE_RESET, SLOW_RESET,
                       BAND_HIGH_RESET, BAND_LOW_RESET};
  int                err_hist [3] = '{0, 0, 0};
  longint            drive_acc    = 0;
  int                travel_rem   = 0;
  logic [DIST_W-1:0] travel_cnt   = '0;

  duty_result_t pending_duties [$];
  duty_result_t oldest;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int errors        = 0;
  int quiet_cycles  = 0;

  function automatic int pick_target(input tick_t t, output bit on_straight);
    int sum, mean, k;
    sum = 0;
    for (k = 0; k < CENTRE_NUM; k++) sum += int'(t.centre[k]);
    mean = sum / CENTRE_NUM;
    on_straight = 1'b0;
    if (t.mode == MODE_SLOW) return int'(gains.slow_speed);
    if (t.mode != MODE_CROSSING &&
        (mean > int'(gains.band_high) || mean < int'(gains.band_low)))
      return int'(gains.curve_speed);
    on_straight = 1'b1;
    return int'(gains.straight_speed);
  endfunction

  function automatic duty_result_t advance_controller(input tick_t t);
    bit           straight;
    int           tgt, enc, speed, e0, e1, e2;
    longint       drive;
    duty_result_t r;
    tgt   = pick_target(t, straight);
    enc   = $signed(t.enc);
    speed = -enc;

    travel_rem += speed;
    if (travel_rem > int'(TRAVEL_STEP)) begin
      travel_cnt = travel_cnt + 16'd1;
      travel_rem = 0;
    end
    if (travel_rem < int'(REMAINDER_FLOOR)) travel_rem = int'(REMAINDER_FLOOR);

    err_hist[2] = err_hist[1];
    err_hist[1] = err_hist[0];
    err_hist[0] = tgt - speed;
    e0 = err_hist[0];
    e1 = err_hist[1];
    e2 = err_hist[2];

    // Signed division truncates toward zero, as the P and D terms require.
    drive = drive_acc + longint'(e0) * longint'(gains.integ_gain)
          + (longint'(e0 - e1) * longint'(gains.prop_gain)) / 10
          + (longint'(e0 - 2 * e1 + e2) * longint'(gains.deriv_gain)) / 10;
    if (e0 >= int'(BANG_THRESHOLD) && straight) drive = longint'(DRIVE_LIMIT);
    if (e0 <= -int'(BANG_THRESHOLD)) drive = -longint'(DRIVE_LIMIT);
    if (drive > longint'(DRIVE_LIMIT)) drive = longint'(DRIVE_LIMIT);
    if (drive < -longint'(DRIVE_LIMIT)) drive = -longint'(DRIVE_LIMIT);
    drive_acc = drive;

    r          = '0;
    r.tgt      = 8'(tgt);
    r.distance = travel_cnt;
    if (!t.halt) begin
      if (drive > 0) r.fwd = 13'(drive);
      else r.rev = 13'(-drive);
    end
    return r;
  endfunction

  // Mostly a car tracking its target with random centres and small speed
  // errors; the rest is raw noise over every field.
  function automatic tick_t next_tick();
    tick_t t;
    int    level, v, k, tgt, delta;
    bit    unused;
    if ($urandom_range(99) < 25) begin
      for (k = 0; k < CENTRE_NUM; k++) t.centre[k] = 8'($urandom_range(255));
      t.enc  = 12'($urandom_range(4095));
      t.mode = 2'($urandom_range(3));
      t.halt = 1'($urandom_range(1));
      return t;
    end
    level = $urandom_range(1) ? int'($urandom_range(20, 60)) : int'($urandom_range(255));
    for (k = 0; k < CENTRE_NUM; k++) begin
      v = level + int'($urandom_range(12)) - 6;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      t.centre[k] = 8'(v);
    end
    v = $urandom_range(99);
    t.mode = (v < 70) ? ROAD_NORMAL : (v < 80) ? MODE_CROSSING :
             (v < 92) ? MODE_SLOW : ROAD_SPARE;
    t.halt = ($urandom_range(19) == 0);
    tgt    = pick_target(t, unused);
    delta  = ($urandom_range(9) == 0) ? int'($urandom_range(160)) - 80
                                      : int'($urandom_range(44)) - 22;
    t.enc  = 12'(-(tgt + delta));
    return t;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Leaves valid high; the caller drops it once the last request is taken.
  task automatic send_tick(input tick_t t, input bit typed, input duty_result_t want);
    duty_result_t seen;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.centre_row_a  <= t.centre[0];
    in_ch.centre_row_b  <= t.centre[1];
    in_ch.centre_row_c  <= t.centre[2];
    in_ch.centre_row_d  <= t.centre[3];
    in_ch.centre_row_e  <= t.centre[4];
    in_ch.centre_row_f  <= t.centre[5];
    in_ch.centre_row_g  <= t.centre[6];
    in_ch.centre_row_h  <= t.centre[7];
    in_ch.centre_row_i  <= t.centre[8];
    in_ch.encoder_count <= t.enc;
    in_ch.road_mode     <= t.mode;
    in_ch.halt          <= t.halt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    seen = advance_controller(t);
    pending_duties.push_back(typed ? want : seen);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [9:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_PROP_GAIN:      gains.prop_gain      = data;
      CFG_INTEG_GAIN:     gains.integ_gain     = data[7:0];
      CFG_DERIV_GAIN:     gains.deriv_gain     = data;
      CFG_STRAIGHT_SPEED: gains.straight_speed = data[7:0];
      CFG_CURVE_SPEED:    gains.curve_speed    = data[7:0];
      CFG_SLOW_SPEED:     gains.slow_speed     = data[7:0];
      CFG_BAND_HIGH:      gains.band_high      = data[7:0];
      CFG_BAND_LOW:       gains.band_low       = data[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [9:0] kp, ki, kd, fast, curve, slow, hi, lo);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_DERIV_GAIN, kd);
    write_reg(CFG_STRAIGHT_SPEED, fast);
    write_reg(CFG_CURVE_SPEED, curve);
    write_reg(CFG_SLOW_SPEED, slow);
    write_reg(CFG_BAND_HIGH, hi);
    write_reg(CFG_BAND_LOW, lo);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Result side: random back-pressure plus long hold-offs on request.
  initial begin
    int hold_left, hold_taken;
    hold_left  = 0;
    hold_taken = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_left  = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct) ? 1'b1 : 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_duties.size() == 0) begin
        errors++;
        $display("%0t: unexpected result fwd=%0d rev=%0d target=%0d dist=%0d", $time,
                 out_ch.forward_duty, out_ch.reverse_duty, out_ch.target_speed,
                 out_ch.distance_units);
      end else begin
        oldest = pending_duties.pop_front();
        check_field("forward_duty", 16'(oldest.fwd), 16'(out_ch.forward_duty));
        check_field("reverse_duty", 16'(oldest.rev), 16'(out_ch.reverse_duty));
        check_field("target_speed", 16'(oldest.tgt), 16'(out_ch.target_speed));
        check_field("distance_units", oldest.distance, out_ch.distance_units);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [PLAN_ROWS];
    tick_t     t;
    int        p, n, k;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.centre_row_a  <= '0;
    in_ch.centre_row_b  <= '0;
    in_ch.centre_row_c  <= '0;
    in_ch.centre_row_d  <= '0;
    in_ch.centre_row_e  <= '0;
    in_ch.centre_row_f  <= '0;
    in_ch.centre_row_g  <= '0;
    in_ch.centre_row_h  <= '0;
    in_ch.centre_row_i  <= '0;
    in_ch.encoder_count <= '0;
    in_ch.road_mode     <= ROAD_NORMAL;
    in_ch.halt          <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_PROP_GAIN;
    cfg_ch.data         <= '0;

    // Reset settings: zero gains, so the drive only moves on bang-bang.
    plan[0]  = '{8'd40, 8'd40, 12'sd0, ROAD_NORMAL, 1'b0, '{DUTY_FULL, 13'd0, 8'd70, 16'd0}};
    plan[1]  = '{8'd255, 8'd255, 12'sd0, ROAD_NORMAL, 1'b0, '{DUTY_FULL, 13'd0, 8'd55, 16'd0}};
    plan[2]  = '{8'd0, 8'd0, 12'sd2047, MODE_SLOW, 1'b0, '{DUTY_FULL, 13'd0, 8'd40, 16'd0}};
    plan[3]  = '{8'd0, 8'd0, 12'sh800, MODE_CROSSING, 1'b0, '{13'd0, DUTY_FULL, 8'd70, 16'd0}};
    plan[4]  = '{8'd40, 8'd40, -12'sd400, ROAD_NORMAL, 1'b1, '{13'd0, 13'd0, 8'd70, 16'd1}};
    plan[5]  = '{8'd255, 8'd255, 12'sd0, ROAD_SPARE, 1'b0, '{13'd0, DUTY_FULL, 8'd55, 16'd1}};
    plan[6]  = '{8'd52, 8'd52, -12'sd50, ROAD_NORMAL, 1'b0, '{DUTY_FULL, 13'd0, 8'd70, 16'd1}};
    plan[7]  = '{8'd28, 8'd28, -12'sd51, ROAD_NORMAL, 1'b1, '{13'd0, 13'd0, 8'd70, 16'd1}};
    plan[8]  = '{8'd53, 8'd53, -12'sd75, ROAD_NORMAL, 1'b0, '{13'd0, DUTY_FULL, 8'd55, 16'd1}};
    plan[9]  = '{8'd27, 8'd27, -12'sd74, ROAD_NORMAL, 1'b0, '{13'd0, DUTY_FULL, 8'd55, 16'd1}};
    plan[10] = '{8'd255, 8'd0, -12'sd70, ROAD_NORMAL, 1'b0, '{13'd0, DUTY_FULL, 8'd70, 16'd1}};
    plan[11] = '{8'd251, 8'd0, -12'sd31, ROAD_NORMAL, 1'b0, '{13'd0, DUTY_FULL, 8'd55, 16'd2}};
    // Drive the travel remainder into its floor, then climb back to a count.
    plan[12] = '{8'd0, 8'd0, 12'sd2047, MODE_SLOW, 1'b0, '{13'd0, DUTY_FULL, 8'd40, 16'd2}};
    plan[13] = '{8'd0, 8'd0, 12'sd2047, MODE_SLOW, 1'b0, '{13'd0, DUTY_FULL, 8'd40, 16'd2}};
    plan[14] = '{8'd0, 8'd0, 12'sd2047, MODE_SLOW, 1'b0, '{13'd0, DUTY_FULL, 8'd40, 16'd2}};
    plan[15] = '{8'd0, 8'd0, 12'sh800, MODE_SLOW, 1'b0, '{13'd0, DUTY_FULL, 8'd40, 16'd2}};
    plan[16] = '{8'd0, 8'd0, 12'sh800, MODE_SLOW, 1'b0, '{13'd0, DUTY_FULL, 8'd40, 16'd2}};
    plan[17] = '{8'd0, 8'd0, -12'sd351, MODE_SLOW, 1'b0, '{13'd0, DUTY_FULL, 8'd40, 16'd3}};
    plan[18] = '{8'd40, 8'd40, 12'sd0, ROAD_SPARE, 1'b0, '{DUTY_FULL, 13'd0, 8'd70, 16'd3}};

    send_idle_pct = 34;
    recv_idle_pct = 64;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < PLAN_ROWS; k++) begin
      t.centre    = {CENTRE_NUM{plan[k].rest}};
      t.centre[0] = plan[k].first;
      t.enc       = plan[k].enc;
      t.mode      = plan[k].mode;
      t.halt      = plan[k].halt;
      send_tick(t, 1'b1, plan[k].want);
    end
    in_ch.valid <= 1'b0;
    drain_results();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_settings(10'($urandom_range(60)), 10'($urandom_range(6)),
                          10'($urandom_range(60)), 10'(STRAIGHT_RESET), 10'(CURVE_RESET),
                          10'(SLOW_RESET), 10'(BAND_HIGH_RESET), 10'(BAND_LOW_RESET));
        1: apply_settings(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF,
                          10'h3FF);
        2: apply_settings('0, '0, '0, '0, '0, '0, '0, '0);
        3: apply_settings(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                          10'($urandom_range(1023)), 10'($urandom_range(1023)),
                          10'($urandom_range(1023)), 10'($urandom_range(1023)),
                          10'($urandom_range(1023)), 10'($urandom_range(1023)));
        4: apply_settings(10'($urandom_range(60)), 10'($urandom_range(6)),
                          10'($urandom_range(60)), 10'($urandom_range(20, 120)),
                          10'($urandom_range(20, 120)), 10'($urandom_range(20, 120)),
                          10'($urandom_range(40, 90)), 10'($urandom_range(10, 40)));
        default: apply_settings(10'($urandom_range(1023)), 10'($urandom_range(3)),
                                10'($urandom_range(1023)), 10'(STRAIGHT_RESET),
                                10'(CURVE_RESET), 10'(SLOW_RESET), 10'(BAND_HIGH_RESET),
                                10'(BAND_LOW_RESET));
      endcase
      if (p < 2) begin
        send_idle_pct = 34;
        recv_idle_pct = 64;
      end else if (p < 4) begin
        send_idle_pct = 64;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Stall the result side long enough to back up into the input.
        if (n == 10 && (p == 0 || p == 4)) hold_asked++;
        if (p == 2 && n == ITEMS_PER_PHASE / 2) begin
          in_ch.valid <= 1'b0;
          drain_results();
        end
        send_tick(next_tick(), 1'b0, '0);
      end
      in_ch.valid <= 1'b0;
      drain_results();
    end

    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: incremental_pid_speed_controller_top.f
design/ipsc_pkg.sv
design/ipsc_channels.sv
design/incremental_pid_speed_controller_top.sv
bench/tb_top.sv
